FILE: sv/rafp_pkg.sv
`timescale 1ns / 1ps

package rafp_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'hFE;
  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam int unsigned MM_PER_COUNT = 45;

  localparam int unsigned RAW_W  = 16;
  localparam int unsigned DIST_W = 22;

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_HEADER   = 3'd1,
    PH_VERSION  = 3'd2,
    PH_ALT_LOW  = 3'd3,
    PH_ALT_HIGH = 3'd4,
    PH_SNR      = 3'd5,
    PH_CHECKSUM = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD        = 2'd0,
    ST_JUNK        = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_BAD_SUM     = 2'd3
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [RAW_W-1:0] raw;
    logic [7:0]       snr;
  } res_t;

endpackage

FILE: sv/rafp_parse.sv
`timescale 1ns / 1ps

module rafp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output rafp_pkg::res_t    res
);

  rafp_pkg::phase_t phase;
  rafp_pkg::phase_t phase_next;
  logic [7:0] altitude_low;
  logic [7:0] altitude_high;
  logic [7:0] snr_held;
  logic [7:0] sum;

  assign sum = rafp_pkg::VERSION_BYTE + altitude_high + altitude_low + snr_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rafp_pkg::PH_HUNT;
      altitude_low  <= 8'd0;
      altitude_high <= 8'd0;
      snr_held      <= 8'd0;
    end else if (in_fire) begin
      phase <= phase_next;
      if (phase == rafp_pkg::PH_ALT_LOW)  altitude_low  <= rx_byte;
      if (phase == rafp_pkg::PH_ALT_HIGH) altitude_high <= rx_byte;
      if (phase == rafp_pkg::PH_SNR)      snr_held      <= rx_byte;
    end
  end

  always_comb begin
    phase_next = phase;
    res_valid  = 1'b0;
    res.status = rafp_pkg::ST_GOOD;
    res.raw    = '0;
    res.snr    = '0;
    unique case (phase)
      rafp_pkg::PH_HUNT: begin
        if (rx_byte == rafp_pkg::HEADER_BYTE) phase_next = rafp_pkg::PH_VERSION;
      end
      rafp_pkg::PH_HEADER: begin
        if (rx_byte == rafp_pkg::HEADER_BYTE) begin
          phase_next = rafp_pkg::PH_VERSION;
        end else begin
          // junk where the next header should be; byte is not re-examined
          phase_next = rafp_pkg::PH_HUNT;
          res_valid  = in_fire;
          res.status = rafp_pkg::ST_JUNK;
        end
      end
      rafp_pkg::PH_VERSION: begin
        if (rx_byte == rafp_pkg::VERSION_BYTE) begin
          phase_next = rafp_pkg::PH_ALT_LOW;
        end else begin
          phase_next = rafp_pkg::PH_HUNT;
          res_valid  = in_fire;
          res.status = rafp_pkg::ST_BAD_VERSION;
        end
      end
      rafp_pkg::PH_ALT_LOW:  phase_next = rafp_pkg::PH_ALT_HIGH;
      rafp_pkg::PH_ALT_HIGH: phase_next = rafp_pkg::PH_SNR;
      rafp_pkg::PH_SNR:      phase_next = rafp_pkg::PH_CHECKSUM;
      rafp_pkg::PH_CHECKSUM: begin
        phase_next = rafp_pkg::PH_HEADER;
        res_valid  = in_fire;
        res.status = (sum == rx_byte) ? rafp_pkg::ST_GOOD : rafp_pkg::ST_BAD_SUM;
        res.raw    = {altitude_high, altitude_low};
        res.snr    = snr_held;
      end
      default: phase_next = rafp_pkg::PH_HUNT;
    endcase
  end

  a_res_needs_request: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_fire)
    else $error("result raised without an accepted byte");

  a_checksum_to_header: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == rafp_pkg::PH_CHECKSUM) |=> phase == rafp_pkg::PH_HEADER)
    else $error("checksum byte did not leave parser expecting a header");

  a_snr_captured: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == rafp_pkg::PH_SNR) |=> snr_held == $past(rx_byte))
    else $error("SNR byte not captured");

endmodule

FILE: sv/rafp_out.sv
`timescale 1ns / 1ps

module rafp_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  input  rafp_pkg::res_t                res,
  output logic                          up_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [rafp_pkg::DIST_W-1:0]   distance_mm,
  output logic [rafp_pkg::RAW_W-1:0]    raw_altitude,
  output logic [7:0]                    snr_value
);

  logic [rafp_pkg::DIST_W-1:0] dist_next;

  assign up_ready = !out_valid || out_ready;

  always_comb begin
    dist_next = '0;
    if (res.status == rafp_pkg::ST_GOOD) begin
      dist_next = {{(rafp_pkg::DIST_W-rafp_pkg::RAW_W){1'b0}}, res.raw}
                  * rafp_pkg::DIST_W'(rafp_pkg::MM_PER_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status       <= res.status;
      distance_mm  <= dist_next;
      raw_altitude <= res.raw;
      snr_value    <= res.snr;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid) |-> out_ready)
    else $error("result overwrote one still waiting");

  a_distance_only_good: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != rafp_pkg::ST_GOOD) |-> distance_mm == '0)
    else $error("distance set on an error result");

  a_distance_scaled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rafp_pkg::ST_GOOD) |->
      distance_mm == rafp_pkg::DIST_W'(raw_altitude * rafp_pkg::DIST_W'(rafp_pkg::MM_PER_COUNT)))
    else $error("distance does not match raw altitude");

endmodule

FILE: sv/radar_altimeter_frame_parser.sv
`timescale 1ns / 1ps

// Parses six-byte altimeter frames (0xFE, 0x01, alt low, alt high, SNR, sum) from a
// byte stream, one byte per cycle. Each byte is consumed in the cycle it is accepted;
// the frame's last byte, a bad version byte or junk after a frame puts one result in
// the output register, visible the next cycle. Input ready is high whenever the
// output register is empty or being drained, so a full-rate stream keeps flowing
// as long as out_ready stays high; distance_mm is raw altitude times 45.
module radar_altimeter_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [rafp_pkg::DIST_W-1:0]   distance_mm,
  output logic [rafp_pkg::RAW_W-1:0]    raw_altitude,
  output logic [7:0]                    snr_value
);

  logic           in_fire;
  logic           res_valid;
  rafp_pkg::res_t res;

  assign in_fire = in_valid && in_ready;

  rafp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  rafp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .up_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .distance_mm  (distance_mm),
    .raw_altitude (raw_altitude),
    .snr_value    (snr_value)
  );

endmodule

FILE: sim/tb_radar_altimeter_frame_parser.sv
`timescale 1ns / 1ps

module tb_radar_altimeter_frame_parser;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int BYTES_PER_PASS  = 583;
  localparam int DRAIN_CYCLES    = 10;

  typedef struct {
    rafp_pkg::status_t           status;
    logic [rafp_pkg::DIST_W-1:0] distance;
    logic [rafp_pkg::RAW_W-1:0]  raw;
    logic [7:0]                  snr;
  } frame_result_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  rx_byte;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  status;
  logic [rafp_pkg::DIST_W-1:0] distance_mm;
  logic [rafp_pkg::RAW_W-1:0]  raw_altitude;
  logic [7:0]                  snr_value;

  // frame parser shadow state
  rafp_pkg::phase_t parse_phase;
  logic [7:0] alt_lo;
  logic [7:0] alt_hi;
  logic [7:0] snr_held;

  frame_result_t expected_results[$];
  int errors       = 0;
  int cycles       = 0;
  int bytes_sent   = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  radar_altimeter_frame_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .distance_mm  (distance_mm),
    .raw_altitude (raw_altitude),
    .snr_value    (snr_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic push_result(input rafp_pkg::status_t st,
                             input logic [rafp_pkg::RAW_W-1:0] raw,
                             input logic [7:0] snr);
    frame_result_t r;
    r.status   = st;
    r.raw      = raw;
    r.snr      = snr;
    r.distance = (st == rafp_pkg::ST_GOOD) ?
                 rafp_pkg::DIST_W'(raw * rafp_pkg::MM_PER_COUNT) : '0;
    expected_results.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [7:0]                 sum;
    logic [rafp_pkg::RAW_W-1:0] raw;
    case (parse_phase)
      rafp_pkg::PH_HUNT: begin
        if (b == rafp_pkg::HEADER_BYTE) parse_phase = rafp_pkg::PH_VERSION;
      end
      rafp_pkg::PH_HEADER: begin
        if (b == rafp_pkg::HEADER_BYTE) begin
          parse_phase = rafp_pkg::PH_VERSION;
        end else begin
          parse_phase = rafp_pkg::PH_HUNT;
          push_result(rafp_pkg::ST_JUNK, '0, '0);
        end
      end
      rafp_pkg::PH_VERSION: begin
        if (b == rafp_pkg::VERSION_BYTE) begin
          parse_phase = rafp_pkg::PH_ALT_LOW;
        end else begin
          // the offending byte is consumed, even if it looks like a header
          parse_phase = rafp_pkg::PH_HUNT;
          push_result(rafp_pkg::ST_BAD_VERSION, '0, '0);
        end
      end
      rafp_pkg::PH_ALT_LOW: begin
        alt_lo      = b;
        parse_phase = rafp_pkg::PH_ALT_HIGH;
      end
      rafp_pkg::PH_ALT_HIGH: begin
        alt_hi      = b;
        parse_phase = rafp_pkg::PH_SNR;
      end
      rafp_pkg::PH_SNR: begin
        snr_held    = b;
        parse_phase = rafp_pkg::PH_CHECKSUM;
      end
      rafp_pkg::PH_CHECKSUM: begin
        raw         = {alt_hi, alt_lo};
        sum         = rafp_pkg::VERSION_BYTE + alt_hi + alt_lo + snr_held;
        parse_phase = rafp_pkg::PH_HEADER;
        push_result((sum == b) ? rafp_pkg::ST_GOOD : rafp_pkg::ST_BAD_SUM, raw, snr_held);
      end
      default: parse_phase = rafp_pkg::PH_HUNT;
    endcase
  endtask

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] alt, input logic [7:0] snr, input bit good);
    logic [7:0] sum;
    sum = rafp_pkg::VERSION_BYTE + alt[7:0] + alt[15:8] + snr;
    if (!good) sum = sum + 8'($urandom_range(1, 255));
    send_byte(rafp_pkg::HEADER_BYTE);
    send_byte(rafp_pkg::VERSION_BYTE);
    send_byte(alt[7:0]);
    send_byte(alt[15:8]);
    send_byte(snr);
    send_byte(sum);
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d raw_altitude %0h", status, raw_altitude);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (distance_mm !== want.distance) begin
          $error("distance_mm: expected %0d, got %0d", want.distance, distance_mm);
          errors++;
        end
        if (raw_altitude !== want.raw) begin
          $error("raw_altitude: expected %0h, got %0h", want.raw, raw_altitude);
          errors++;
        end
        if (snr_value !== want.snr) begin
          $error("snr_value: expected %0h, got %0h", want.snr, snr_value);
          errors++;
        end
      end
    end
  end

  task automatic test_good_frame_extremes();
    send_frame(16'h0000, 8'h00, 1'b1);
    // header right after a frame, all-ones payload wraps the checksum
    send_frame(16'hFFFF, 8'hFF, 1'b1);
  endtask

  task automatic test_junk_after_frame();
    send_byte(8'h00);
  endtask

  task automatic test_bad_version();
    send_byte(8'hFF);                     // dropped while hunting
    send_byte(rafp_pkg::VERSION_BYTE);    // dropped while hunting
    send_byte(rafp_pkg::HEADER_BYTE);
    send_byte(8'h02);
    send_byte(rafp_pkg::HEADER_BYTE);
    send_byte(rafp_pkg::HEADER_BYTE);     // a header in the version slot is rejected
    send_byte(rafp_pkg::VERSION_BYTE);
  endtask

  task automatic test_bad_checksum();
    send_frame(16'h1234, 8'h80, 1'b0);
  endtask

  task automatic send_random_unit();
    int         pick;
    int         shape;
    int         n;
    logic [15:0] alt;
    logic [7:0]  snr;
    logic [7:0]  ver;
    pick  = $urandom_range(99);
    shape = $urandom_range(9);
    alt   = (shape == 0) ? 16'h0000 : (shape == 1) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
    snr   = 8'($urandom_range(255));
    if (pick < 70) begin
      send_frame(alt, snr, 1'b1);
    end else if (pick < 80) begin
      send_frame(alt, snr, 1'b0);
    end else if (pick < 88) begin
      do ver = 8'($urandom_range(255)); while (ver == rafp_pkg::VERSION_BYTE);
      send_byte(rafp_pkg::HEADER_BYTE);
      send_byte(ver);
    end else if (pick < 95) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      // broken frame: header, then a few arbitrary bytes
      n = $urandom_range(1, 4);
      send_byte(rafp_pkg::HEADER_BYTE);
      repeat (n) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_stream(input int snd_pct, input int rcv_pct);
    int start;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = bytes_sent;
    while (bytes_sent - start < BYTES_PER_PASS) send_random_unit();
  endtask

  initial begin
    parse_phase = rafp_pkg::PH_HUNT;
    alt_lo      = '0;
    alt_hi      = '0;
    snr_held    = '0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    rx_byte  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 35;
    rcv_idle_pct = 52;
    test_good_frame_extremes();
    test_junk_after_frame();
    test_bad_version();
    test_bad_checksum();

    test_random_stream(35, 52);
    test_random_stream(52, 35);
    test_random_stream(0, 0);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
